>>> hdl/wst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wst_pkg
// Shared types and constants of the weighted sum tree sampler.
// ----------------------------------------------------------------------------
package wst_pkg;

    localparam int LOG2_LEAVES_DEF = 10;
    localparam int SUM_WIDTH_DEF   = 48;

    localparam int REQ_W   = 2;
    localparam int LEAF_W  = 10;
    localparam int AMT_W   = 33;
    localparam int DRAW_W  = 48;
    localparam int TOTAL_W = 48;

    typedef enum logic [REQ_W-1:0] {
        REQ_ADD     = 2'd0,
        REQ_SAMPLE  = 2'd1,
        REQ_WRITE   = 2'd2,
        REQ_REBUILD = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD,
        ST_SAMPLE,
        ST_REBUILD,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [LEAF_W-1:0]  chosen_leaf;
        logic [TOTAL_W-1:0] total_weight;
        logic               saturated;
    } t_rsp;

endpackage

>>> hdl/wst_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wst_req_if / wst_rsp_if
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface wst_req_if;
    logic                                valid;
    logic                                ready;
    logic [wst_pkg::REQ_W-1:0]           req_type;
    logic [wst_pkg::LEAF_W-1:0]          leaf_index;
    logic signed [wst_pkg::AMT_W-1:0]    amount;
    logic [wst_pkg::DRAW_W-1:0]          draw;

    modport source (output valid, req_type, leaf_index, amount, draw, input ready);
    modport sink   (input valid, req_type, leaf_index, amount, draw, output ready);
endinterface

interface wst_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [wst_pkg::LEAF_W-1:0]          chosen_leaf;
    logic [wst_pkg::TOTAL_W-1:0]         total_weight;
    logic                                saturated;

    modport source (output valid, chosen_leaf, total_weight, saturated, input ready);
    modport sink   (input valid, chosen_leaf, total_weight, saturated, output ready);
endinterface

>>> hdl/wst_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wst_mem
// Node sum memory: one write port, two registered read ports with
// write-to-read forwarding for same-cycle accesses to one entry.
// ----------------------------------------------------------------------------
module wst_mem #(
    parameter int AW = wst_pkg::LOG2_LEAVES_DEF + 1,
    parameter int DW = wst_pkg::SUM_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr0,
    input  logic [AW-1:0] i_raddr1,
    output logic [DW-1:0] o_rdata0,
    output logic [DW-1:0] o_rdata1
);

    logic [DW-1:0] r_mem [0:(1 << AW)-1];
    logic [DW-1:0] r_q0;
    logic [DW-1:0] r_q1;
    logic [DW-1:0] r_wd;
    logic          r_fwd0;
    logic          r_fwd1;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q0   <= r_mem[i_raddr0];
        r_q1   <= r_mem[i_raddr1];
        r_wd   <= i_wdata;
        r_fwd0 <= i_we && (i_waddr == i_raddr0);
        r_fwd1 <= i_we && (i_waddr == i_raddr1);
    end

    assign o_rdata0 = r_fwd0 ? r_wd : r_q0;
    assign o_rdata1 = r_fwd1 ? r_wd : r_q1;

endmodule

>>> hdl/wst_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wst_ctrl
// Request sequencer: clearing pass, raw leaf write, path update, descent and
// rebuild over the node memory, with a shadow copy of the root sum.
// ----------------------------------------------------------------------------
module wst_ctrl #(
    parameter int LOG2_LEAVES = wst_pkg::LOG2_LEAVES_DEF,
    parameter int SUM_WIDTH   = wst_pkg::SUM_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    wst_req_if.sink                     i_req,
    input  logic                        i_rsp_ready,
    output logic                        o_done,
    output wst_pkg::t_rsp               o_rsp,
    output logic                        o_we,
    output logic [LOG2_LEAVES:0]        o_waddr,
    output logic [SUM_WIDTH-1:0]        o_wdata,
    output logic [LOG2_LEAVES:0]        o_raddr0,
    output logic [LOG2_LEAVES:0]        o_raddr1,
    input  logic [SUM_WIDTH-1:0]        i_rdata0,
    input  logic [SUM_WIDTH-1:0]        i_rdata1
);

    localparam int AW = LOG2_LEAVES + 1;
    localparam int XW = (SUM_WIDTH > wst_pkg::DRAW_W) ? SUM_WIDTH : wst_pkg::DRAW_W;
    localparam int EW = ((SUM_WIDTH > wst_pkg::AMT_W) ? SUM_WIDTH : wst_pkg::AMT_W) + 1;
    localparam int CW = $clog2(LOG2_LEAVES + 1);
    localparam logic [SUM_WIDTH-1:0] SUM_MAX    = '1;
    localparam logic [AW-1:0]        LAST_INNER = AW'((1 << LOG2_LEAVES) - 1);
    localparam logic [AW-1:0]        ROOT       = AW'(1);
    localparam logic [CW-1:0]        LAST_LVL   = CW'(LOG2_LEAVES - 1);

    wst_pkg::t_state               r_state, n_state;
    logic [AW-1:0]                 r_node, n_node;
    logic [XW-1:0]                 r_x, n_x;
    logic                          r_neg, n_neg;
    logic [wst_pkg::AMT_W-1:0]     r_mag, n_mag;
    logic                          r_sat, n_sat;
    logic [wst_pkg::LEAF_W-1:0]    r_leaf, n_leaf;
    logic [CW-1:0]                 r_cnt, n_cnt;
    logic [SUM_WIDTH-1:0]          r_root, n_root;

    wst_pkg::t_req                 w_req;
    logic                          w_accept;
    logic [LOG2_LEAVES-1:0]        w_leaf;
    logic [AW-1:0]                 w_leaf_node;
    logic [wst_pkg::AMT_W-1:0]     w_amt;
    logic                          w_neg;
    logic [wst_pkg::AMT_W-1:0]     w_mag;
    logic                          w_wr_big;
    logic [EW-1:0]                 w_add_sum;
    logic                          w_add_ovf;
    logic                          w_sub_under;
    logic [SUM_WIDTH-1:0]          w_add_new;
    logic [XW-1:0]                 w_left;
    logic                          w_go_right;
    logic [AW-1:0]                 w_next_node;
    logic [SUM_WIDTH:0]            w_pair;
    logic [AW-1:0]                 w_prev;

    assign i_req.ready = (r_state == wst_pkg::ST_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_req       = wst_pkg::t_req'(i_req.req_type);
    assign w_leaf      = LOG2_LEAVES'(i_req.leaf_index);
    assign w_leaf_node = {1'b1, w_leaf};
    assign w_amt       = $unsigned(i_req.amount);
    assign w_neg       = w_amt[wst_pkg::AMT_W-1];
    assign w_mag       = w_neg ? (~w_amt + 1'b1) : w_amt;
    assign w_wr_big    = EW'(w_mag) > EW'(SUM_MAX);

    // path update arithmetic
    assign w_add_sum   = EW'(i_rdata0) + EW'(r_mag);
    assign w_add_ovf   = w_add_sum > EW'(SUM_MAX);
    assign w_sub_under = EW'(i_rdata0) < EW'(r_mag);
    always_comb begin
        if (r_neg) begin
            w_add_new = w_sub_under ? '0 : SUM_WIDTH'(EW'(i_rdata0) - EW'(r_mag));
        end else begin
            w_add_new = w_add_ovf ? SUM_MAX : w_add_sum[SUM_WIDTH-1:0];
        end
    end

    // descent step
    assign w_left      = XW'(i_rdata0);
    assign w_go_right  = (r_x >= w_left);
    assign w_next_node = {r_node[AW-2:0], w_go_right};

    // rebuild step
    assign w_pair = {1'b0, i_rdata0} + {1'b0, i_rdata1};
    assign w_prev = r_node - 1'b1;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            wst_pkg::ST_CLEAR: begin
                if (r_node == '1) begin
                    n_state = wst_pkg::ST_IDLE;
                end
            end
            wst_pkg::ST_IDLE: begin
                if (w_accept) begin
                    unique case (w_req)
                        wst_pkg::REQ_ADD:     n_state = wst_pkg::ST_ADD;
                        wst_pkg::REQ_SAMPLE:  n_state = wst_pkg::ST_SAMPLE;
                        wst_pkg::REQ_WRITE:   n_state = wst_pkg::ST_DONE;
                        wst_pkg::REQ_REBUILD: n_state = wst_pkg::ST_REBUILD;
                        default:              n_state = wst_pkg::ST_IDLE;
                    endcase
                end
            end
            wst_pkg::ST_ADD: begin
                if (r_node == ROOT) begin
                    n_state = wst_pkg::ST_DONE;
                end
            end
            wst_pkg::ST_SAMPLE: begin
                if (r_cnt == LAST_LVL) begin
                    n_state = wst_pkg::ST_DONE;
                end
            end
            wst_pkg::ST_REBUILD: begin
                if (r_node == ROOT) begin
                    n_state = wst_pkg::ST_DONE;
                end
            end
            wst_pkg::ST_DONE: begin
                if (i_rsp_ready) begin
                    n_state = wst_pkg::ST_IDLE;
                end
            end
            default: n_state = wst_pkg::ST_CLEAR;
        endcase
    end

    always_comb begin
        o_we     = 1'b0;
        o_waddr  = r_node;
        o_wdata  = '0;
        o_raddr0 = '0;
        o_raddr1 = '0;
        n_node   = r_node;
        n_x      = r_x;
        n_neg    = r_neg;
        n_mag    = r_mag;
        n_sat    = r_sat;
        n_leaf   = r_leaf;
        n_cnt    = r_cnt;
        unique case (r_state)
            wst_pkg::ST_CLEAR: begin
                o_we   = 1'b1;
                n_node = r_node + 1'b1;
            end
            wst_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_neg  = w_neg;
                    n_mag  = w_mag;
                    n_sat  = 1'b0;
                    n_leaf = '0;
                    n_cnt  = '0;
                    unique case (w_req)
                        wst_pkg::REQ_ADD: begin
                            o_raddr0 = w_leaf_node;
                            n_node   = w_leaf_node;
                        end
                        wst_pkg::REQ_SAMPLE: begin
                            o_raddr0 = AW'(2);
                            n_node   = ROOT;
                            n_x      = XW'(i_req.draw);
                        end
                        wst_pkg::REQ_WRITE: begin
                            o_we    = 1'b1;
                            o_waddr = w_leaf_node;
                            if (w_neg) begin
                                o_wdata = '0;
                            end else if (w_wr_big) begin
                                o_wdata = SUM_MAX;
                            end else begin
                                o_wdata = SUM_WIDTH'(w_mag);
                            end
                            n_sat = w_neg || w_wr_big;
                        end
                        wst_pkg::REQ_REBUILD: begin
                            o_raddr0 = {LAST_INNER[AW-2:0], 1'b0};
                            o_raddr1 = {LAST_INNER[AW-2:0], 1'b1};
                            n_node   = LAST_INNER;
                        end
                        default: n_node = r_node;
                    endcase
                end
            end
            wst_pkg::ST_ADD: begin
                o_we     = 1'b1;
                o_wdata  = w_add_new;
                n_sat    = r_sat | (r_neg ? w_sub_under : w_add_ovf);
                o_raddr0 = r_node >> 1;
                n_node   = r_node >> 1;
            end
            wst_pkg::ST_SAMPLE: begin
                o_raddr0 = {w_next_node[AW-2:0], 1'b0};
                n_node   = w_next_node;
                n_x      = w_go_right ? (r_x - w_left) : r_x;
                n_cnt    = CW'(r_cnt + 1'b1);
                if (r_cnt == LAST_LVL) begin
                    n_leaf = wst_pkg::LEAF_W'(w_next_node[LOG2_LEAVES-1:0]);
                end
            end
            wst_pkg::ST_REBUILD: begin
                o_we     = 1'b1;
                o_wdata  = w_pair[SUM_WIDTH] ? SUM_MAX : w_pair[SUM_WIDTH-1:0];
                n_sat    = r_sat | w_pair[SUM_WIDTH];
                o_raddr0 = {w_prev[AW-2:0], 1'b0};
                o_raddr1 = {w_prev[AW-2:0], 1'b1};
                n_node   = w_prev;
            end
            wst_pkg::ST_DONE: begin
                n_node = r_node;
            end
            default: n_node = r_node;
        endcase
    end

    // shadow of the root entry
    always_comb begin
        n_root = r_root;
        if (o_we && (o_waddr == ROOT)) begin
            n_root = o_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wst_pkg::ST_CLEAR;
            r_node  <= '0;
            r_sat   <= 1'b0;
            r_leaf  <= '0;
            r_cnt   <= '0;
            r_root  <= '0;
        end else begin
            r_state <= n_state;
            r_node  <= n_node;
            r_sat   <= n_sat;
            r_leaf  <= n_leaf;
            r_cnt   <= n_cnt;
            r_root  <= n_root;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x   <= n_x;
        r_neg <= n_neg;
        r_mag <= n_mag;
    end

    assign o_done              = (r_state == wst_pkg::ST_DONE);
    assign o_rsp.chosen_leaf   = r_leaf;
    assign o_rsp.total_weight  = wst_pkg::TOTAL_W'(r_root);
    assign o_rsp.saturated     = r_sat;

endmodule

>>> hdl/weighted_sum_tree_sampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_sum_tree_sampler
// Binary sum tree over 2^LOG2_LEAVES leaf weights for weighted sampling.
//
// i_req carries one request (add delta up the path, sample, raw leaf write,
// rebuild); o_rsp returns one response per request with the chosen leaf,
// the root total and a saturation flag. Both use valid/ready.
// The tree lives in one node memory (one write, two registered reads); a
// sequencer walks it one node per cycle, one request at a time.
// A raw leaf write is made in the accept cycle; sample descends from the
// root to a leaf, add updates the path from the leaf up to the root, and
// rebuild sums every inner node, one per cycle, from the last up to the root.
// The next request is accepted in the cycle its predecessor's response turns
// valid, while the receiver keeps up.
// After reset a clearing pass zeroes all 2^(LOG2_LEAVES+1) entries, one per
// cycle; i_req.ready stays low until it is done.
// The response sits in an output register; a stalled receiver holds it
// there and the next request is taken once the sequencer has handed off.
// ----------------------------------------------------------------------------
module weighted_sum_tree_sampler #(
    parameter int LOG2_LEAVES = wst_pkg::LOG2_LEAVES_DEF,
    parameter int SUM_WIDTH   = wst_pkg::SUM_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wst_req_if.sink     i_req,
    wst_rsp_if.source   o_rsp
);

    localparam int AW = LOG2_LEAVES + 1;

    logic                  w_we;
    logic [AW-1:0]         w_waddr;
    logic [SUM_WIDTH-1:0]  w_wdata;
    logic [AW-1:0]         w_raddr0;
    logic [AW-1:0]         w_raddr1;
    logic [SUM_WIDTH-1:0]  w_rdata0;
    logic [SUM_WIDTH-1:0]  w_rdata1;
    logic                  w_done;
    wst_pkg::t_rsp         w_rsp;
    logic                  w_rsp_ready;
    logic                  w_load;

    logic                  r_out_valid;
    wst_pkg::t_rsp         r_out;

    wst_ctrl #(
        .LOG2_LEAVES (LOG2_LEAVES),
        .SUM_WIDTH   (SUM_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_rsp_ready (w_rsp_ready),
        .o_done      (w_done),
        .o_rsp       (w_rsp),
        .o_we        (w_we),
        .o_waddr     (w_waddr),
        .o_wdata     (w_wdata),
        .o_raddr0    (w_raddr0),
        .o_raddr1    (w_raddr1),
        .i_rdata0    (w_rdata0),
        .i_rdata1    (w_rdata1)
    );

    wst_mem #(
        .AW (AW),
        .DW (SUM_WIDTH)
    ) u_mem (
        .i_clk    (i_clk),
        .i_we     (w_we),
        .i_waddr  (w_waddr),
        .i_wdata  (w_wdata),
        .i_raddr0 (w_raddr0),
        .i_raddr1 (w_raddr1),
        .o_rdata0 (w_rdata0),
        .o_rdata1 (w_rdata1)
    );

    // response register
    assign w_rsp_ready = !r_out_valid || o_rsp.ready;
    assign w_load      = w_done && w_rsp_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= w_rsp;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.chosen_leaf  = r_out.chosen_leaf;
    assign o_rsp.total_weight = r_out.total_weight;
    assign o_rsp.saturated    = r_out.saturated;

endmodule
